// ===== rtl/cwi_pkg.sv =====
`timescale 1ns / 1ps
package cwi_pkg;

	// Default table depth and stored coordinate width
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 32;

	// Distances below this many LSB count as a degenerate segment
	localparam int NEAR_LIMIT = 7;

	// Register reset values and indexes
	localparam logic [31:0] SPEED_RESET = 32'h0001_0000;
	localparam logic        REG_SPEED   = 1'b0;
	localparam logic        REG_ENABLE  = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_APPEND  = 3'd1,
		OP_REMOVE  = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_RESTART = 3'd4
	} cwi_op_t;

endpackage

// ===== rtl/cyclic_waypoint_interpolator_top.sv =====
`timescale 1ns / 1ps
// Every command ends by blending the output position from the previous and destination
// points (zero with an empty table); remove first shifts each later point down by one, and
// a tick first takes the square-root distance, multiplies delta_time by speed, divides.
// busy falls in the done cycle; start is ignored while busy; the result port cannot stall.
// Reset clears count, index, progress and registers; the point table is not cleared.
module cyclic_waypoint_interpolator_top #(
	parameter int MAX_POINTS = cwi_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = cwi_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [31:0]        wr_data,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic [31:0]        delta_time,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [5:0]         slot,
	output logic               done,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [5:0]         segment,
	output logic [15:0]        fraction,
	output logic [6:0]         count,
	output logic               status
);
	import cwi_pkg::*;

	localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int SQW  = 2 * CW + 4;
	localparam int DW   = CW + 2;
	localparam int BW   = CW + 17;

	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_RDA, S_RDB, S_RDC, S_SQLD, S_SQ, S_SQRT, S_MULLD, S_MUL,
		S_DIV, S_SUM, S_BLD, S_BL, S_SHR, S_SHW, S_POS, S_OUT
	} state_t;

	state_t              state_q;
	logic [31:0]         speed_q;
	logic                enable_q;
	logic [CNTW-1:0]     cnt_q;
	logic [AW-1:0]       dest_q;
	logic [15:0]         prog_q;
	logic [2:0]          op_q;
	logic [31:0]         dt_q;
	logic [3*CW-1:0]     pt_in_q;
	logic [5:0]          slot_q;
	logic                stat_q;
	logic                blend_mode_q;
	logic [AW-1:0]       idx_q;
	logic [6:0]          iter_q;
	logic [1:0]          k_q;
	logic [3*CW-1:0]     a_q;
	logic [3*CW-1:0]     b_q;
	logic [3*CW-1:0]     rd_data_q;
	logic [3*CW-1:0]     mem [MAX_POINTS];
	logic [SQW-1:0]      ma_q;
	logic [CW:0]         mb_q;
	logic [SQW-1:0]      sumsq_q;
	logic [CW+2:0]       rem_q;
	logic [DW-1:0]       root_q;
	logic [63:0]         mc_q;
	logic [31:0]         md_q;
	logic [63:0]         quo_q;
	logic [DW-1:0]       drem_q;
	logic signed [BW-1:0] bacc_q;
	logic signed [BW-1:0] bmul_q;
	logic [15:0]         t_q;
	logic [31:0]         pos_q [3];
	logic                done_q;

	logic [AW-1:0]       prev_idx;
	logic [AW-1:0]       rd_addr;
	logic                wr_mem;
	logic [AW-1:0]       wr_addr;
	logic [3*CW-1:0]     wr_val;
	logic [CW-1:0]       a_k;
	logic [CW-1:0]       b_k;
	logic signed [CW:0]  sdiff;
	logic [CW:0]         udiff;
	logic [CW+4:0]       rem2;
	logic [CW+4:0]       trial;
	logic [DW:0]         drem2;
	logic [16:0]         psum;
	logic                last_pt;
	logic [AW-1:0]       dest_next;
	logic [CW-1:0]       blend_res;
	logic [10:0]         slot_w;
	logic [10:0]         cnt_w;

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign pos_x    = pos_q[0];
	assign pos_y    = pos_q[1];
	assign pos_z    = pos_q[2];
	assign segment  = 6'(dest_q);
	assign fraction = prog_q;
	assign count    = 7'(cnt_q);
	assign status   = stat_q;

	// Neighbor indexes and operand selection
	always_comb begin
		prev_idx  = (dest_q == '0) ? AW'(cnt_q - 1'b1) : dest_q - 1'b1;
		dest_next = (CNTW'(dest_q) + 1'b1 == cnt_q) ? '0 : dest_q + 1'b1;
		a_k       = a_q[k_q*CW +: CW];
		b_k       = b_q[k_q*CW +: CW];
		sdiff     = $signed({b_k[CW-1], b_k}) - $signed({a_k[CW-1], a_k});
		udiff     = sdiff[CW] ? (CW+1)'(-sdiff) : sdiff;
		rem2      = {rem_q, sumsq_q[SQW-1 -: 2]};
		trial     = {1'b0, root_q, 2'b01};
		drem2     = {drem_q, quo_q[63]};
		psum      = {1'b0, prog_q} + {1'b0, quo_q[15:0]};
		blend_res = a_k + CW'(bacc_q >>> 16);
		last_pt   = (11'(idx_q) + 11'd2 >= 11'(cnt_q));
		slot_w    = 11'(slot_q);
		cnt_w     = 11'(cnt_q);
	end

	// Memory port control
	always_comb begin
		case (state_q)
			S_RDA:   rd_addr = prev_idx;
			S_RDB:   rd_addr = dest_q;
			S_SHR:   rd_addr = idx_q + 1'b1;
			default: rd_addr = dest_q;
		endcase
		wr_mem  = 1'b0;
		wr_addr = idx_q;
		wr_val  = rd_data_q;
		if (state_q == S_EXEC && cwi_op_t'(op_q) == OP_APPEND && cnt_q < CNTW'(MAX_POINTS)) begin
			wr_mem  = 1'b1;
			wr_addr = AW'(cnt_q);
			wr_val  = pt_in_q;
		end else if (state_q == S_SHW) begin
			wr_mem = 1'b1;
		end
	end

	// Point table
	always_ff @(posedge clk) begin
		if (wr_mem) begin
			mem[wr_addr] <= wr_val;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= SPEED_RESET;
			enable_q <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == REG_SPEED) begin
				speed_q <= wr_data;
			end else begin
				enable_q <= wr_data[0];
			end
		end
	end

	// Sequencer and serial datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			dest_q       <= '0;
			prog_q       <= '0;
			done_q       <= 1'b0;
			stat_q       <= 1'b0;
			blend_mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						dt_q    <= delta_time;
						pt_in_q <= {coord_z[CW-1:0], coord_y[CW-1:0], coord_x[CW-1:0]};
						slot_q  <= slot;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					stat_q  <= 1'b0;
					state_q <= S_POS;
					case (op_q)
						OP_TICK: begin
							if (enable_q && cnt_q != '0) begin
								if (CNTW'(dest_q) >= cnt_q) dest_q <= '0;
								blend_mode_q <= 1'b0;
								state_q      <= S_RDA;
							end
						end
						OP_APPEND: begin
							if (cnt_q < CNTW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
							else stat_q <= 1'b1;
						end
						OP_REMOVE: begin
							if (slot_w >= cnt_w) begin
								stat_q <= 1'b1;
							end else begin
								idx_q <= AW'(slot_q);
								if (slot_w + 11'd1 < cnt_w) state_q <= S_SHR;
								else cnt_q <= cnt_q - 1'b1;
							end
						end
						OP_CLEAR: begin
							cnt_q  <= '0;
							dest_q <= '0;
							prog_q <= '0;
						end
						OP_RESTART: begin
							dest_q <= '0;
							prog_q <= '0;
						end
						default: stat_q <= 1'b1;
					endcase
				end
				// Shift later points down by one
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					idx_q <= idx_q + 1'b1;
					if (last_pt) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_POS;
					end else begin
						state_q <= S_SHR;
					end
				end
				// Fetch previous and destination points
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					a_q     <= rd_data_q;
					state_q <= S_RDC;
				end
				S_RDC: begin
					b_q     <= rd_data_q;
					k_q     <= 2'd0;
					sumsq_q <= '0;
					state_q <= blend_mode_q ? S_BLD : S_SQLD;
				end
				// Sum of squared differences, shift-add
				S_SQLD: begin
					ma_q    <= SQW'(udiff);
					mb_q    <= udiff;
					iter_q  <= 7'(CW + 1);
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (mb_q[0]) sumsq_q <= sumsq_q + ma_q;
					ma_q   <= ma_q << 1;
					mb_q   <= mb_q >> 1;
					iter_q <= iter_q - 1'b1;
					if (iter_q == 7'd1) begin
						if (k_q == 2'd2) begin
							rem_q   <= '0;
							root_q  <= '0;
							iter_q  <= 7'(CW + 2);
							state_q <= S_SQRT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_SQLD;
						end
					end
				end
				// Square root, two bits per step
				S_SQRT: begin
					sumsq_q <= sumsq_q << 2;
					iter_q  <= iter_q - 1'b1;
					if (rem2 >= trial) begin
						rem_q  <= (CW+3)'(rem2 - trial);
						root_q <= {root_q[DW-2:0], 1'b1};
					end else begin
						rem_q  <= (CW+3)'(rem2);
						root_q <= {root_q[DW-2:0], 1'b0};
					end
					if (iter_q == 7'd1) state_q <= S_MULLD;
				end
				S_MULLD: begin
					if (root_q < DW'(NEAR_LIMIT)) begin
						dest_q  <= dest_next;
						prog_q  <= '0;
						state_q <= S_POS;
					end else begin
						mc_q    <= 64'(speed_q);
						md_q    <= dt_q;
						quo_q   <= '0;
						iter_q  <= 7'd32;
						state_q <= S_MUL;
					end
				end
				// delta_time * speed, shift-add
				S_MUL: begin
					if (md_q[0]) quo_q <= quo_q + mc_q;
					mc_q   <= mc_q << 1;
					md_q   <= md_q >> 1;
					iter_q <= iter_q - 1'b1;
					if (iter_q == 7'd1) begin
						drem_q  <= '0;
						iter_q  <= 7'd64;
						state_q <= S_DIV;
					end
				end
				// Restoring divide by the distance
				S_DIV: begin
					iter_q <= iter_q - 1'b1;
					if (drem2 >= {1'b0, root_q}) begin
						drem_q <= DW'(drem2 - {1'b0, root_q});
						quo_q  <= {quo_q[62:0], 1'b1};
					end else begin
						drem_q <= DW'(drem2);
						quo_q  <= {quo_q[62:0], 1'b0};
					end
					if (iter_q == 7'd1) state_q <= S_SUM;
				end
				S_SUM: begin
					if (quo_q[63:16] != '0 || psum[16]) begin
						dest_q <= dest_next;
						prog_q <= '0;
					end else begin
						prog_q <= psum[15:0];
					end
					state_q <= S_POS;
				end
				// Result position
				S_POS: begin
					if (cnt_q == '0) begin
						pos_q[0] <= '0;
						pos_q[1] <= '0;
						pos_q[2] <= '0;
						state_q  <= S_OUT;
					end else begin
						if (CNTW'(dest_q) >= cnt_q) dest_q <= '0;
						blend_mode_q <= 1'b1;
						state_q      <= S_RDA;
					end
				end
				S_BLD: begin
					bacc_q  <= '0;
					bmul_q  <= BW'(sdiff);
					t_q     <= prog_q;
					iter_q  <= 7'd16;
					state_q <= S_BL;
				end
				S_BL: begin
					if (t_q[0]) bacc_q <= bacc_q + bmul_q;
					bmul_q <= bmul_q <<< 1;
					t_q    <= t_q >> 1;
					iter_q <= iter_q - 1'b1;
					if (iter_q == 7'd0) begin
						pos_q[k_q] <= 32'($signed(blend_res));
						if (k_q == 2'd2) begin
							state_q <= S_OUT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_BLD;
						end
					end
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_POINTS)) else $error("point count beyond table");
	a_dest_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((cnt_q == '0 && dest_q == '0) || CNTW'(dest_q) < cnt_q))
		else $error("destination index outside table");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !$past(done_q) && state_q == S_IDLE)
		else $error("done not a single pulse");
	a_empty_prog: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && cnt_q == '0) |-> (pos_q[0] == '0 && pos_q[1] == '0 && pos_q[2] == '0))
		else $error("nonzero position with empty table");
`endif

endmodule
